/* rtl/crt_pkg.sv */
// shared types and constants for the catmull-rom curve tessellator
package crt_pkg;

   // coordinate and arithmetic widths
   localparam int COORD_W  = 24;
   localparam int WEIGHT_W = 18;
   localparam int PROD_W   = WEIGHT_W + COORD_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam int FRAC_W   = 16;
   localparam int Q_W      = ACC_W - FRAC_W;

   // unity weight in q1.16, used for pass-through points
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);
   // rounding offset before dropping the weight fraction
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

   // command queue depth between front and back
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = 1;
   localparam int CMD_CNT_W = 2;

   // configuration register indexes and port widths
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_SMOOTHING = 1'b0;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type [3:0] quad_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      logic      curve_end;
   } req_payload_type;

   typedef struct packed {
      coord_type out_x;
      coord_type out_y;
      logic      last_of_run;
   } rsp_payload_type;

   typedef enum logic {
      CMD_PASS,
      CMD_SEG
   } cmd_mode_type;

   // one unit of work for the back end
   typedef struct packed {
      cmd_mode_type mode;
      logic         close_seg;
      quad_type     px;
      quad_type     py;
   } cmd_type;

endpackage

/* rtl/crt_front.sv */
// front end: point window, curve bookkeeping and command generation
module crt_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     smoothing_enable,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  crt_pkg::req_payload_type req_payload,
   input  logic                     fifo_full,
   output logic                     push_valid,
   output crt_pkg::cmd_type         push_cmd
);

   logic                accept;
   logic [1:0]          seen_ff;
   logic [1:0]          seen_in;
   crt_pkg::coord_type  win_x_ff [3];
   crt_pkg::coord_type  win_y_ff [3];
   crt_pkg::coord_type  win_x_in [3];
   crt_pkg::coord_type  win_y_in [3];

   assign req_stall = fifo_full;
   assign accept    = req_valid && !req_stall;

   // classify the point and build the command for the back end
   always_comb begin
      push_cmd   = '0;
      push_valid = 1'b0;
      if (!smoothing_enable || seen_ff == 2'd0 ||
          (seen_ff == 2'd1 && req_payload.curve_end)) begin
         push_valid      = accept;
         push_cmd.mode   = crt_pkg::CMD_PASS;
         push_cmd.px[3]  = req_payload.point_x;
         push_cmd.py[3]  = req_payload.point_y;
      end else if (seen_ff >= 2'd2) begin
         push_valid         = accept;
         push_cmd.mode      = crt_pkg::CMD_SEG;
         push_cmd.close_seg = req_payload.curve_end;
         push_cmd.px[0]     = (seen_ff == 2'd2) ? win_x_ff[1] : win_x_ff[0];
         push_cmd.py[0]     = (seen_ff == 2'd2) ? win_y_ff[1] : win_y_ff[0];
         push_cmd.px[1]     = win_x_ff[1];
         push_cmd.py[1]     = win_y_ff[1];
         push_cmd.px[2]     = win_x_ff[2];
         push_cmd.py[2]     = win_y_ff[2];
         push_cmd.px[3]     = req_payload.point_x;
         push_cmd.py[3]     = req_payload.point_y;
      end
   end

   // window shift and point count
   always_comb begin
      win_x_in = win_x_ff;
      win_y_in = win_y_ff;
      seen_in  = seen_ff;
      if (accept) begin
         if (req_payload.curve_end) begin
            seen_in = 2'd0;
         end else begin
            win_x_in[0] = win_x_ff[1];
            win_y_in[0] = win_y_ff[1];
            win_x_in[1] = win_x_ff[2];
            win_y_in[1] = win_y_ff[2];
            win_x_in[2] = req_payload.point_x;
            win_y_in[2] = req_payload.point_y;
            seen_in     = (seen_ff == 2'd3) ? 2'd3 : seen_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 2'd0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      win_x_ff <= win_x_in;
      win_y_ff <= win_y_in;
   end

endmodule

/* rtl/crt_cmd_fifo.sv */
// short command queue between front and back ends
module crt_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  crt_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output crt_pkg::cmd_type head_cmd
);

   crt_pkg::cmd_type                 mem_ff [crt_pkg::CMD_DEPTH];
   logic [crt_pkg::CMD_PTR_W-1:0]    wr_ptr_ff;
   logic [crt_pkg::CMD_PTR_W-1:0]    wr_ptr_in;
   logic [crt_pkg::CMD_PTR_W-1:0]    rd_ptr_ff;
   logic [crt_pkg::CMD_PTR_W-1:0]    rd_ptr_in;
   logic [crt_pkg::CMD_CNT_W-1:0]    count_ff;
   logic [crt_pkg::CMD_CNT_W-1:0]    count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full       = (count_ff == crt_pkg::CMD_CNT_W'(crt_pkg::CMD_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/crt_back.sv */
// back end: step sequencer and weighted-sum pipeline for curve samples
module crt_back #(
   parameter int STEPS = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  crt_pkg::cmd_type         head_cmd,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output crt_pkg::rsp_payload_type rsp_payload
);

   localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);
   localparam logic signed [crt_pkg::Q_W-1:0] SAT_HI =
      {{(crt_pkg::Q_W - crt_pkg::COORD_W + 1){1'b0}}, {(crt_pkg::COORD_W - 1){1'b1}}};
   localparam logic signed [crt_pkg::Q_W-1:0] SAT_LO =
      {{(crt_pkg::Q_W - crt_pkg::COORD_W + 1){1'b1}}, {(crt_pkg::COORD_W - 1){1'b0}}};

   // basis weight table, one entry per basis weight and sample step
   logic signed [crt_pkg::WEIGHT_W-1:0] wt_tab [4][STEPS];

   for (genvar g = 0; g < STEPS; g++) begin : g_wt
      localparam longint S   = longint'(g) + 1;
      localparam longint NS  = longint'(STEPS);
      localparam longint DEN = 2 * NS * NS * NS;
      localparam longint NUM0 = -S * NS * NS + 2 * S * S * NS - S * S * S;
      localparam longint NUM1 = 2 * NS * NS * NS - 5 * S * S * NS + 3 * S * S * S;
      localparam longint NUM2 = S * NS * NS + 4 * S * S * NS - 3 * S * S * S;
      localparam longint NUM3 = S * S * S - S * S * NS;
      localparam longint W0 = (NUM0 >= 0) ? (131072 * NUM0 + DEN) / (2 * DEN)
                                          : -((131072 * (-NUM0) + DEN) / (2 * DEN));
      localparam longint W1 = (NUM1 >= 0) ? (131072 * NUM1 + DEN) / (2 * DEN)
                                          : -((131072 * (-NUM1) + DEN) / (2 * DEN));
      localparam longint W2 = (NUM2 >= 0) ? (131072 * NUM2 + DEN) / (2 * DEN)
                                          : -((131072 * (-NUM2) + DEN) / (2 * DEN));
      localparam longint W3 = (NUM3 >= 0) ? (131072 * NUM3 + DEN) / (2 * DEN)
                                          : -((131072 * (-NUM3) + DEN) / (2 * DEN));
      assign wt_tab[0][g] = W0[crt_pkg::WEIGHT_W-1:0];
      assign wt_tab[1][g] = W1[crt_pkg::WEIGHT_W-1:0];
      assign wt_tab[2][g] = W2[crt_pkg::WEIGHT_W-1:0];
      assign wt_tab[3][g] = W3[crt_pkg::WEIGHT_W-1:0];
   end

   // sequencer state
   crt_pkg::cmd_type    cur_ff;
   crt_pkg::cmd_type    cur_in;
   logic                cur_valid_ff;
   logic                cur_valid_in;
   logic [STEP_W-1:0]   step_ff;
   logic [STEP_W-1:0]   step_in;
   logic                seg2_ff;
   logic                seg2_in;

   // pipeline state
   logic                                 adv;
   logic                                 issue;
   logic                                 final_sample;
   logic signed [crt_pkg::WEIGHT_W-1:0]  wt [4];
   crt_pkg::quad_type                    opx;
   crt_pkg::quad_type                    opy;
   logic signed [crt_pkg::PROD_W-1:0]    prod_x_ff [4];
   logic signed [crt_pkg::PROD_W-1:0]    prod_y_ff [4];
   logic signed [crt_pkg::PROD_W-1:0]    prod_x_in [4];
   logic signed [crt_pkg::PROD_W-1:0]    prod_y_in [4];
   logic                                 s1_valid_ff;
   logic                                 s1_last_ff;
   logic signed [crt_pkg::ACC_W-1:0]     acc_x_ff;
   logic signed [crt_pkg::ACC_W-1:0]     acc_y_ff;
   logic signed [crt_pkg::ACC_W-1:0]     acc_x_in;
   logic signed [crt_pkg::ACC_W-1:0]     acc_y_in;
   logic                                 s2_valid_ff;
   logic                                 s2_last_ff;
   logic signed [crt_pkg::ACC_W-1:0]     rnd_x;
   logic signed [crt_pkg::ACC_W-1:0]     rnd_y;
   logic signed [crt_pkg::Q_W-1:0]       q_x;
   logic signed [crt_pkg::Q_W-1:0]       q_y;
   crt_pkg::rsp_payload_type             rsp_payload_ff;
   crt_pkg::rsp_payload_type             rsp_payload_in;
   logic                                 rsp_valid_ff;

   // whole pipeline moves unless the output register is held
   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign issue = cur_valid_ff && adv;

   // operand and weight selection for the current step
   always_comb begin
      if (cur_ff.mode == crt_pkg::CMD_PASS) begin
         wt[0] = '0;
         wt[1] = '0;
         wt[2] = '0;
         wt[3] = crt_pkg::WEIGHT_ONE;
      end else begin
         wt[0] = wt_tab[0][step_ff];
         wt[1] = wt_tab[1][step_ff];
         wt[2] = wt_tab[2][step_ff];
         wt[3] = wt_tab[3][step_ff];
      end
      // closing segment reuses the end point as the last control point
      if (seg2_ff) begin
         opx = {cur_ff.px[3], cur_ff.px[3], cur_ff.px[2], cur_ff.px[1]};
         opy = {cur_ff.py[3], cur_ff.py[3], cur_ff.py[2], cur_ff.py[1]};
      end else begin
         opx = cur_ff.px;
         opy = cur_ff.py;
      end
      final_sample = (cur_ff.mode == crt_pkg::CMD_PASS) ||
                     (step_ff == STEP_LAST && (!cur_ff.close_seg || seg2_ff));
   end

   // step sequencing and command load
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      seg2_in      = seg2_ff;
      pop          = head_valid && adv && (!cur_valid_ff || final_sample);
      if (issue) begin
         if (final_sample) begin
            cur_valid_in = 1'b0;
         end else if (step_ff == STEP_LAST) begin
            step_in = '0;
            seg2_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
      if (pop) begin
         cur_in       = head_cmd;
         cur_valid_in = 1'b1;
         step_in      = '0;
         seg2_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= '0;
         seg2_ff      <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
         seg2_ff      <= seg2_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // stage 1: one x and one y multiplier per lane
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prod_x_in[i] = wt[i] * $signed(opx[i]);
         prod_y_in[i] = wt[i] * $signed(opy[i]);
      end
   end

   // stage 2: four-term sum
   always_comb begin
      acc_x_in = crt_pkg::ACC_W'(prod_x_ff[0]) + crt_pkg::ACC_W'(prod_x_ff[1]) +
                 crt_pkg::ACC_W'(prod_x_ff[2]) + crt_pkg::ACC_W'(prod_x_ff[3]);
      acc_y_in = crt_pkg::ACC_W'(prod_y_ff[0]) + crt_pkg::ACC_W'(prod_y_ff[1]) +
                 crt_pkg::ACC_W'(prod_y_ff[2]) + crt_pkg::ACC_W'(prod_y_ff[3]);
   end

   // stage 3: round to nearest and saturate
   always_comb begin
      rnd_x = acc_x_ff + crt_pkg::ROUND_HALF;
      rnd_y = acc_y_ff + crt_pkg::ROUND_HALF;
      q_x   = rnd_x[crt_pkg::ACC_W-1:crt_pkg::FRAC_W];
      q_y   = rnd_y[crt_pkg::ACC_W-1:crt_pkg::FRAC_W];
      if (q_x > SAT_HI) begin
         rsp_payload_in.out_x = SAT_HI[crt_pkg::COORD_W-1:0];
      end else if (q_x < SAT_LO) begin
         rsp_payload_in.out_x = SAT_LO[crt_pkg::COORD_W-1:0];
      end else begin
         rsp_payload_in.out_x = q_x[crt_pkg::COORD_W-1:0];
      end
      if (q_y > SAT_HI) begin
         rsp_payload_in.out_y = SAT_HI[crt_pkg::COORD_W-1:0];
      end else if (q_y < SAT_LO) begin
         rsp_payload_in.out_y = SAT_LO[crt_pkg::COORD_W-1:0];
      end else begin
         rsp_payload_in.out_y = q_y[crt_pkg::COORD_W-1:0];
      end
      rsp_payload_in.last_of_run = s2_last_ff;
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // pipeline data
   always_ff @(posedge clock) begin
      if (adv) begin
         prod_x_ff      <= prod_x_in;
         prod_y_ff      <= prod_y_in;
         s1_last_ff     <= final_sample;
         acc_x_ff       <= acc_x_in;
         acc_y_ff       <= acc_y_in;
         s2_last_ff     <= s1_last_ff;
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* rtl/catmull_rom_curve_tessellator.sv */
// top level of the catmull-rom curve tessellator
//
// Points enter on the req_ channel (valid/stall), one transaction per point,
// with curve_end marking the last point of a curve. Samples leave on the rsp_
// channel, last_of_run set on the final sample caused by a point.
// The first point of a curve, any point of a one- or two-point curve, and
// every point while smoothing is off give one sample equal to the point.
// The second point of a longer curve gives nothing; each later point gives
// STEPS samples, and the last point of the curve gives 2*STEPS.
// Throughput is one sample per cycle from a single back-end pipeline, as long
// as rsp_stall does not hold the output.
// The first sample of a point passes the command queue, step issue, multiply,
// sum and round stages before it appears on the rsp_ side.
// A two-entry command queue sits between front and back ends, so points are
// still taken while samples wait on the rsp_ side; req_stall rises when full.
// With rsp_valid high, rsp_stall freezes the whole pipeline, its output held.
// Reset (synchronous) clears the point count, the queue and the pipeline and
// sets smoothing_enable; the csr_ port holds it at byte address 0.
module catmull_rom_curve_tessellator #(
   parameter int STEPS = 20
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  crt_pkg::req_payload_type           req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output crt_pkg::rsp_payload_type           rsp_payload,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [crt_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [crt_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [crt_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   logic             smoothing_ff;
   logic             smoothing_in;
   logic             csr_write;
   logic             fifo_full;
   logic             push_valid;
   crt_pkg::cmd_type push_cmd;
   logic             pop;
   logic             head_valid;
   crt_pkg::cmd_type head_cmd;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      smoothing_in = smoothing_ff;
      if (csr_write && csr_paddr[2] == crt_pkg::CSR_IDX_SMOOTHING) begin
         smoothing_in = csr_pwdata[0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == crt_pkg::CSR_IDX_SMOOTHING) begin
         csr_prdata[0] = smoothing_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smoothing_ff <= 1'b1;
      end else begin
         smoothing_ff <= smoothing_in;
      end
   end

   crt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .smoothing_enable (smoothing_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .fifo_full        (fifo_full),
      .push_valid       (push_valid),
      .push_cmd         (push_cmd)
   );

   crt_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (fifo_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   crt_back #(
      .STEPS (STEPS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
